>>> src/rgb_histogram_engine_top_defines.svh
// ----------------------------------------------------------------------------
// rgb_histogram_engine_top_defines.svh
// Assertion macros for the histogram engine checker.
// ----------------------------------------------------------------------------
`ifndef RGB_HISTOGRAM_ENGINE_TOP_DEFINES_SVH
`define RGB_HISTOGRAM_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define RHE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("histogram engine check failed");

// Next-cycle implication, clocked on i_clk, off while in reset.
`define RHE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("histogram engine check failed");

`endif

>>> src/rhe_pkg.sv
// ----------------------------------------------------------------------------
// rhe_pkg
// Types and constants shared by the RGB histogram engine files.
// ----------------------------------------------------------------------------
`default_nettype none

package rhe_pkg;

    localparam int BINS      = 256;
    localparam int DEPTH     = 3 * BINS;
    localparam int ADDR_W    = 10;
    localparam int MEAN_BITS = 16;
    localparam int STEP_W    = 4;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        ACT_ADD      = 2'd0,
        ACT_READ_BIN = 2'd1,
        ACT_READ_SUM = 2'd2,
        ACT_CLEAR    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD0,
        S_ADD1,
        S_ADD2,
        S_RDBIN,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action    action;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] channel;
        logic [7:0] bin;
    } t_rhe_in;

    typedef struct packed {
        logic [31:0] bin_count;
        logic [31:0] pixel_count;
        logic [31:0] translucent_count;
        logic [15:0] mean_red;
        logic [15:0] mean_green;
        logic [15:0] mean_blue;
    } t_rhe_out;

endpackage

`default_nettype wire

>>> src/rhe_mean_div.sv
// ----------------------------------------------------------------------------
// rhe_mean_div
// Radix-2 restoring divider: floor(sum * 256 / count), one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rhe_mean_div
    import rhe_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [COUNT_BITS+7:0]     i_sum,
    input  wire logic [COUNT_BITS-1:0]     i_count,
    output logic                           o_done,
    output logic [MEAN_BITS-1:0]           o_mean
);

    logic                    r_busy;
    logic                    r_done;
    logic [STEP_W-1:0]       r_step;
    logic [COUNT_BITS-1:0]   r_rem;
    logic [COUNT_BITS-1:0]   r_div;
    logic [MEAN_BITS-1:0]    r_shift;
    logic [MEAN_BITS-1:0]    r_q;
    logic                    r_zero;

    logic [COUNT_BITS:0]     s_trial;
    logic [COUNT_BITS:0]     s_diff;
    logic                    s_ge;

    // sum < 256 * count, so the quotient fits 16 bits and rem < count throughout
    assign s_trial = {r_rem, r_shift[MEAN_BITS-1]};
    assign s_diff  = s_trial - {1'b0, r_div};
    assign s_ge    = (s_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(MEAN_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_sum[COUNT_BITS+7:8];
            r_shift <= {i_sum[7:0], 8'h00};
            r_div   <= i_count;
            r_zero  <= (i_count == '0);
        end else if (r_busy) begin
            r_rem   <= s_ge ? s_diff[COUNT_BITS-1:0] : s_trial[COUNT_BITS-1:0];
            r_shift <= {r_shift[MEAN_BITS-2:0], 1'b0};
            r_q     <= {r_q[MEAN_BITS-2:0], s_ge};
        end
    end

    assign o_done = r_done;
    assign o_mean = r_zero ? '0 : r_q;

endmodule

`default_nettype wire

>>> src/rgb_histogram_engine_top.sv
// ----------------------------------------------------------------------------
// rgb_histogram_engine_top
// RGB 256-bin histograms with pixel count, alpha count and channel means.
// ----------------------------------------------------------------------------
// One item at a time: an add runs S_ADD0, S_ADD1, S_ADD2 and S_DONE, a bin
// read S_RDBIN and S_DONE (only S_DONE for the empty fourth channel), a
// summary read S_DIV and S_DONE, and a clear S_CLEAR and S_DONE, each back
// to S_IDLE once the output register is free. Adds are set by the bin
// memory's one read port: the red, green and blue bins are each read,
// bumped and written back in turn. The summary waits on three 16-step
// dividers that run side by side, and a clear sweeps all 768 bins, one per
// cycle. After reset the same sweep runs before the first item is taken;
// configuration writes are taken at any time. A finished result sits
// in an output register, so the next item is accepted while it waits; that
// item's own result then holds the engine until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_histogram_engine_top
    import rhe_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // configuration: alpha_enable
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata,
    // item input channel
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_rhe_in   i_in_item,
    // result channel
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_rhe_out       o_out_item
);

    localparam int SUM_BITS = COUNT_BITS + 8;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] f_clamp32(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] f_sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state                  r_state, n_state;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic                    r_clr_reply;
    t_rhe_in                 r_item;
    t_rhe_out                r_res, n_res;
    logic                    r_out_valid;
    t_rhe_out                r_out_item;
    logic                    r_alpha_en;

    logic [COUNT_BITS-1:0]   r_total;
    logic [COUNT_BITS-1:0]   r_transl;
    logic [SUM_BITS-1:0]     r_sum_r;
    logic [SUM_BITS-1:0]     r_sum_g;
    logic [SUM_BITS-1:0]     r_sum_b;

    // bin memory: red at 0..255, green at 256..511, blue at 512..767
    logic [COUNT_BITS-1:0]   mem [0:DEPTH-1];
    logic [COUNT_BITS-1:0]   r_rd_data;

    logic                    s_rd_en;
    logic [ADDR_W-1:0]       s_rd_addr;
    logic                    s_wr_en;
    logic [ADDR_W-1:0]       s_wr_addr;
    logic [COUNT_BITS-1:0]   s_wr_data;
    logic                    s_div_start;
    logic                    s_res_set;
    logic                    s_out_load;
    logic                    s_accept;

    logic [2:0]              s_div_done;
    logic [MEAN_BITS-1:0]    s_mean_r, s_mean_g, s_mean_b;

    assign s_accept = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // mean dividers, started together on a summary item
    // ------------------------------------------------------------------
    rhe_mean_div #(.COUNT_BITS(COUNT_BITS)) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_div_start),
        .i_sum   (r_sum_r),
        .i_count (r_total),
        .o_done  (s_div_done[0]),
        .o_mean  (s_mean_r)
    );

    rhe_mean_div #(.COUNT_BITS(COUNT_BITS)) u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_div_start),
        .i_sum   (r_sum_g),
        .i_count (r_total),
        .o_done  (s_div_done[1]),
        .o_mean  (s_mean_g)
    );

    rhe_mean_div #(.COUNT_BITS(COUNT_BITS)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_div_start),
        .i_sum   (r_sum_b),
        .i_count (r_total),
        .o_done  (s_div_done[2]),
        .o_mean  (s_mean_b)
    );

    // ------------------------------------------------------------------
    // sequencer
    // Items never overlap, and the three bins of one add sit in different
    // thirds of the memory, so a read never meets a write still in flight.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        s_rd_en     = 1'b0;
        s_rd_addr   = '0;
        s_wr_en     = 1'b0;
        s_wr_addr   = '0;
        s_wr_data   = '0;
        s_div_start = 1'b0;
        s_res_set   = 1'b0;
        s_out_load  = 1'b0;
        o_in_ready  = 1'b0;
        n_res       = '0;

        unique case (r_state)
            S_CLEAR: begin
                s_wr_en   = 1'b1;
                s_wr_addr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_in_item.action)
                        ACT_ADD: begin
                            s_rd_en   = 1'b1;
                            s_rd_addr = {CH_RED, i_in_item.red};
                            n_state   = S_ADD0;
                        end
                        ACT_READ_BIN: begin
                            // channel 3 has no histogram: answer zero
                            if (i_in_item.channel <= CH_BLUE) begin
                                s_rd_en   = 1'b1;
                                s_rd_addr = {i_in_item.channel, i_in_item.bin};
                                n_state   = S_RDBIN;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        ACT_READ_SUM: begin
                            s_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                        ACT_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD0: begin
                s_wr_en   = 1'b1;
                s_wr_addr = {CH_RED, r_item.red};
                s_wr_data = f_sat_inc(r_rd_data);
                s_rd_en   = 1'b1;
                s_rd_addr = {CH_GREEN, r_item.green};
                n_state   = S_ADD1;
            end
            S_ADD1: begin
                s_wr_en   = 1'b1;
                s_wr_addr = {CH_GREEN, r_item.green};
                s_wr_data = f_sat_inc(r_rd_data);
                s_rd_en   = 1'b1;
                s_rd_addr = {CH_BLUE, r_item.blue};
                n_state   = S_ADD2;
            end
            S_ADD2: begin
                s_wr_en   = 1'b1;
                s_wr_addr = {CH_BLUE, r_item.blue};
                s_wr_data = f_sat_inc(r_rd_data);
                n_state   = S_DONE;
            end
            S_RDBIN: begin
                s_res_set       = 1'b1;
                n_res.bin_count = f_clamp32(r_rd_data);
                n_state         = S_DONE;
            end
            S_DIV: begin
                if (&s_div_done) begin
                    s_res_set               = 1'b1;
                    n_res.pixel_count       = f_clamp32(r_total);
                    n_res.translucent_count = f_clamp32(r_transl);
                    n_res.mean_red          = s_mean_r;
                    n_res.mean_green        = s_mean_g;
                    n_res.mean_blue         = s_mean_b;
                    n_state                 = S_DONE;
                end
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    s_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // clear sweep address; idles at zero so every sweep starts at bin 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end else begin
                r_clr_addr <= '0;
            end
            // the sweep after reset gives no result; a clear item does
            if (s_accept) begin
                r_clr_reply <= (i_in_item.action == ACT_CLEAR);
            end
        end
    end

    // captured item and staged result (zero unless an action fills it)
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item <= i_in_item;
            r_res  <= '0;
        end else if (s_res_set) begin
            r_res  <= n_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_alpha_en <= i_cfg_wdata;
        end
    end

    // counters and sums; sums freeze once the pixel count saturates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_transl <= '0;
            r_sum_r  <= '0;
            r_sum_g  <= '0;
            r_sum_b  <= '0;
        end else if (s_accept && i_in_item.action == ACT_CLEAR) begin
            r_total  <= '0;
            r_transl <= '0;
            r_sum_r  <= '0;
            r_sum_g  <= '0;
            r_sum_b  <= '0;
        end else if (r_state == S_ADD2) begin
            if (r_total != '1) begin
                r_total <= r_total + 1'b1;
                r_sum_r <= r_sum_r + SUM_BITS'(r_item.red);
                r_sum_g <= r_sum_g + SUM_BITS'(r_item.green);
                r_sum_b <= r_sum_b + SUM_BITS'(r_item.blue);
            end
            if (r_alpha_en && r_item.alpha != ALPHA_OPAQUE) begin
                r_transl <= f_sat_inc(r_transl);
            end
        end
    end

    // bin memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            mem[s_wr_addr] <= s_wr_data;
        end
        if (s_rd_en) begin
            r_rd_data <= mem[s_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/rhe_checker.sv
// ----------------------------------------------------------------------------
// rhe_checker
// Port-level checks for the histogram engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_histogram_engine_top_defines.svh"

module rhe_checker
    import rhe_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_rhe_out  i_out_item
);

    // a waiting result holds
    `RHE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item))

    // one item at a time: ready drops right after an accept
    `RHE_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready)

    // a bin read carries nothing else
    `RHE_ASSERT_NOW(a_bin_only, i_out_valid && i_out_item.bin_count != 32'd0,
        i_out_item.pixel_count == 32'd0 && i_out_item.translucent_count == 32'd0 &&
        i_out_item.mean_red == 16'd0 && i_out_item.mean_green == 16'd0 &&
        i_out_item.mean_blue == 16'd0)

    // means never exceed 255.0
    `RHE_ASSERT_NOW(a_mean_range, i_out_valid,
        i_out_item.mean_red <= 16'hFF00 && i_out_item.mean_green <= 16'hFF00 &&
        i_out_item.mean_blue <= 16'hFF00)

    // translucent pixels are a subset of all pixels
    `RHE_ASSERT_NOW(a_transl_le_total, i_out_valid,
        i_out_item.translucent_count <= i_out_item.pixel_count)

endmodule

bind rgb_histogram_engine_top rhe_checker u_rhe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire

>>> tb/rhe_stats_checker.sv
// ----------------------------------------------------------------------------
// rhe_stats_checker
// Watches both item channels of the histogram engine. It keeps its own copy of
// the bins, counters and sums, predicts each result and compares it on arrival.
// ----------------------------------------------------------------------------
module rhe_stats_checker
    import rhe_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_ready,
    input  wire t_rhe_in  i_in_item,
    input  wire logic     i_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_rhe_out i_out_item,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] COUNT_MAX  = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [63:0] REPORT_MAX = 64'hFFFF_FFFF;

    logic [63:0] bin_cnt [DEPTH];
    logic [63:0] pixel_total;
    logic [63:0] translucent_total;
    logic [63:0] red_sum;
    logic [63:0] green_sum;
    logic [63:0] blue_sum;
    logic        alpha_en = 1'b0;

    t_rhe_out    expected_stats [$];
    t_rhe_out    want;
    int          fail_total = 0;
    int          waiting = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = waiting;

    function automatic logic [63:0] bump(input logic [63:0] c);
        return (c < COUNT_MAX) ? c + 64'd1 : c;
    endfunction

    function automatic logic [31:0] report(input logic [63:0] v);
        return (v > REPORT_MAX) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // floor(sum * 256 / count), split so the scaled sum never overflows
    function automatic logic [15:0] mean_8p8(input logic [63:0] sum, input logic [63:0] cnt);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] m;
        if (cnt == 64'd0) begin
            return 16'd0;
        end
        q = sum / cnt;
        r = sum % cnt;
        m = (q << 8) + (r * 64'd256) / cnt;
        return m[15:0];
    endfunction

    task automatic clear_stats();
        for (int i = 0; i < DEPTH; i++) begin
            bin_cnt[i] = 64'd0;
        end
        pixel_total       = 64'd0;
        translucent_total = 64'd0;
        red_sum           = 64'd0;
        green_sum         = 64'd0;
        blue_sum          = 64'd0;
    endtask

    task automatic predict_stats(input t_rhe_in it, output t_rhe_out res);
        res = '0;
        case (it.action)
            ACT_ADD: begin
                bin_cnt[{CH_RED, it.red}]     = bump(bin_cnt[{CH_RED, it.red}]);
                bin_cnt[{CH_GREEN, it.green}] = bump(bin_cnt[{CH_GREEN, it.green}]);
                bin_cnt[{CH_BLUE, it.blue}]   = bump(bin_cnt[{CH_BLUE, it.blue}]);
                // sums freeze with the pixel count so the means stay in range
                if (pixel_total < COUNT_MAX) begin
                    pixel_total = pixel_total + 64'd1;
                    red_sum     = red_sum + it.red;
                    green_sum   = green_sum + it.green;
                    blue_sum    = blue_sum + it.blue;
                end
                if (alpha_en && it.alpha < ALPHA_OPAQUE) begin
                    translucent_total = bump(translucent_total);
                end
            end
            ACT_READ_BIN: begin
                if (it.channel <= CH_BLUE) begin
                    res.bin_count = report(bin_cnt[{it.channel, it.bin}]);
                end
            end
            ACT_READ_SUM: begin
                res.pixel_count       = report(pixel_total);
                res.translucent_count = report(translucent_total);
                res.mean_red          = mean_8p8(red_sum, pixel_total);
                res.mean_green        = mean_8p8(green_sum, pixel_total);
                res.mean_blue         = mean_8p8(blue_sum, pixel_total);
            end
            ACT_CLEAR: begin
                clear_stats();
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
            fail_total++;
        end
    endtask

    // result side is handled before the input side, so a result and an item
    // taken on the same edge pair up correctly
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_stats();
            alpha_en = 1'b0;
            expected_stats.delete();
        end else begin
            if (i_cfg_we) begin
                alpha_en = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $time, i_out_item);
                    fail_total++;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("bin_count", want.bin_count, i_out_item.bin_count);
                    check_field("pixel_count", want.pixel_count, i_out_item.pixel_count);
                    check_field("translucent_count", want.translucent_count,
                                i_out_item.translucent_count);
                    check_field("mean_red", 32'(want.mean_red), 32'(i_out_item.mean_red));
                    check_field("mean_green", 32'(want.mean_green),
                                32'(i_out_item.mean_green));
                    check_field("mean_blue", 32'(want.mean_blue), 32'(i_out_item.mean_blue));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_stats(i_in_item, want);
                expected_stats.push_back(want);
            end
        end
        waiting = expected_stats.size();
    end

endmodule

>>> tb/rgb_histogram_engine_top_tb.sv
// ----------------------------------------------------------------------------
// rgb_histogram_engine_top_tb
// Drives pixels, bin reads, summary reads and clears into the histogram
// engine, toggles the alpha count enable between phases, and lets the
// checker predict and compare every result.
// ----------------------------------------------------------------------------
module rgb_histogram_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rhe_pkg::*;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 16;      // quiet time before an enable write
    localparam int TAIL_CYCLES   = 800;     // covers a full clear sweep
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 300;
    localparam int TIMEOUT_NS    = 10_000_000;

    // channel code that selects no histogram
    localparam logic [1:0] CH_NONE = 2'd3;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     cfg_we    = 1'b0;
    logic     cfg_wdata = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_rhe_in  in_item   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_rhe_out out_item;

    logic     idle_en   = 1'b1;     // random gaps and stalls allowed
    int       fail_count;
    int       pending;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rgb_histogram_engine_top #(
        .COUNT_BITS (32)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    rhe_stats_checker #(
        .COUNT_BITS (32)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Levels cluster at both ends of the range half the time, so bin reads
    // hit populated bins and the shadow and clipped bins fill up.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 3));
            1:       return 8'($urandom_range(252, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_rhe_in make_item(input t_action act, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b,
                                          input logic [7:0] a, input logic [1:0] ch,
                                          input logic [7:0] bn);
        t_rhe_in it;
        it.action  = act;
        it.red     = r;
        it.green   = g;
        it.blue    = b;
        it.alpha   = a;
        it.channel = ch;
        it.bin     = bn;
        return it;
    endfunction

    // Mostly pixels, a fair share of reads, and a rare clear; every field
    // is random even where the action ignores it.
    function automatic t_rhe_in random_item();
        t_rhe_in     it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            it.action = ACT_ADD;
        end else if (pick < 82) begin
            it.action = ACT_READ_BIN;
        end else if (pick < 98) begin
            it.action = ACT_READ_SUM;
        end else begin
            it.action = ACT_CLEAR;
        end
        it.red     = pick_level();
        it.green   = pick_level();
        it.blue    = pick_level();
        it.alpha   = ($urandom_range(0, 4) < 2) ? ALPHA_OPAQUE : 8'($urandom_range(0, 254));
        it.channel = ($urandom_range(0, 9) == 0) ? CH_NONE : 2'($urandom_range(0, 2));
        it.bin     = pick_level();
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item
    // is taken with valid still high, so back-to-back items never drop it.
    task automatic send_item(input t_rhe_in it);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Stop sending, wait for every result, then let the engine settle.
    task automatic drain_results(input int settle);
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic set_alpha_enable(input logic en);
        cfg_wdata <= en;
        cfg_we    <= 1'b1;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: ready drops at random while idling is on.
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, alpha count off (reset value). The engine holds
        // off the first item until its post-reset clear sweep is done.
        // Empty store: mean of zero pixels reads as zero.
        send_item(make_item(ACT_READ_SUM, 8'hA5, 8'h5A, 8'hC3, 8'h00, CH_BLUE, 8'h77));
        send_item(make_item(ACT_READ_BIN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, CH_RED, 8'h00));
        // Extremes; alpha below opaque is ignored while the count is off.
        // Fields the add does not use carry junk.
        send_item(make_item(ACT_ADD, 8'h00, 8'h00, 8'h00, 8'h00, CH_NONE, 8'hFF));
        send_item(make_item(ACT_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, CH_GREEN, 8'h00));
        send_item(make_item(ACT_ADD, 8'h80, 8'h01, 8'hFE, 8'hFE, CH_RED, 8'h80));
        // Shadow and clipped bins, plus a read of the missing fourth channel.
        send_item(make_item(ACT_READ_BIN, 8'h00, 8'h00, 8'h00, 8'h00, CH_RED, 8'h00));
        send_item(make_item(ACT_READ_BIN, 8'h00, 8'h00, 8'h00, 8'h00, CH_GREEN, 8'hFF));
        send_item(make_item(ACT_READ_BIN, 8'h00, 8'h00, 8'h00, 8'h00, CH_BLUE, 8'hFE));
        send_item(make_item(ACT_READ_BIN, 8'h00, 8'h00, 8'h00, 8'h00, CH_NONE, 8'h00));
        send_item(make_item(ACT_READ_SUM, 8'h00, 8'h00, 8'h00, 8'h00, CH_RED, 8'h00));
        // Clear, then confirm everything reads back as zero.
        send_item(make_item(ACT_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'h00, CH_NONE, 8'hFF));
        send_item(make_item(ACT_READ_SUM, 8'h00, 8'h00, 8'h00, 8'h00, CH_RED, 8'h00));
        send_item(make_item(ACT_READ_BIN, 8'h00, 8'h00, 8'h00, 8'h00, CH_BLUE, 8'hFF));
        drain_results(SETTLE_CYCLES);

        // Alpha count on: just below opaque, opaque, fully transparent.
        set_alpha_enable(1'b1);
        send_item(make_item(ACT_ADD, 8'h12, 8'h34, 8'h56, 8'hFE, CH_RED, 8'h00));
        send_item(make_item(ACT_ADD, 8'h12, 8'h34, 8'h56, ALPHA_OPAQUE, CH_RED, 8'h00));
        send_item(make_item(ACT_ADD, 8'h9A, 8'hBC, 8'hDE, 8'h00, CH_RED, 8'h00));
        send_item(make_item(ACT_READ_SUM, 8'h00, 8'h00, 8'h00, 8'h00, CH_RED, 8'h00));
        send_item(make_item(ACT_READ_BIN, 8'h00, 8'h00, 8'h00, 8'h00, CH_GREEN, 8'h34));

        // Random phases: count on, count off, count on with full throughput.
        repeat (PHASE_ITEMS) send_item(random_item());
        drain_results(SETTLE_CYCLES);
        set_alpha_enable(1'b0);
        repeat (PHASE_ITEMS) send_item(random_item());
        drain_results(SETTLE_CYCLES);
        set_alpha_enable(1'b1);
        idle_en = 1'b0;
        repeat (PHASE_ITEMS) send_item(random_item());
        drain_results(TAIL_CYCLES);

        if (pending != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("rgb_histogram_engine_top verification clean");
        end else begin
            $display("rgb_histogram_engine_top verification failed");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #(TIMEOUT_NS);
        $display("rgb_histogram_engine_top verification failed");
        $finish;
    end

endmodule
